/* design/cau_pkg.sv */
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_t;

endpackage

/* design/cau_front.sv */
module cau_front import cau_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  op_t                  in_op,
  input  logic signed [DW-1:0] in_a_re,
  input  logic signed [DW-1:0] in_a_im,
  input  logic signed [DW-1:0] in_b_re,
  input  logic signed [DW-1:0] in_b_im,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_div,
  output logic                 out_dz,
  output logic                 out_neg_re,
  output logic                 out_neg_im,
  output logic [2*DW:0]        out_mag_re,
  output logic [2*DW:0]        out_mag_im,
  output logic [2*DW-1:0]      out_den
);

  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 1;

  logic en1, en2, en3;

  // Stage 1: products and exact sums.
  logic                 v1_r;
  op_t                  op1_r;
  logic signed [DW:0]   sr1_r, si1_r;
  logic signed [PW-1:0] prr1_r, pii1_r, pri1_r, pir1_r, sqr1_r, sqi1_r;

  // Stage 2: combined real and imaginary parts, |b|^2.
  logic                 v2_r;
  op_t                  op2_r;
  logic signed [SW-1:0] re2_r, im2_r;
  logic [PW-1:0]        den2_r;
  logic signed [SW-1:0] re2_nxt, im2_nxt;

  // Stage 3: sign and magnitude.
  logic                 v3_r;
  logic                 div3_r, dz3_r, nre3_r, nim3_r;
  logic [SW-1:0]        mre3_r, mim3_r;
  logic [PW-1:0]        den3_r;
  logic [SW-1:0]        mre_nxt, mim_nxt;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
    if (en1) begin
      op1_r  <= in_op;
      sr1_r  <= (in_op == OP_SUB) ? (DW+1)'(in_a_re) - (DW+1)'(in_b_re)
                                  : (DW+1)'(in_a_re) + (DW+1)'(in_b_re);
      si1_r  <= (in_op == OP_SUB) ? (DW+1)'(in_a_im) - (DW+1)'(in_b_im)
                                  : (DW+1)'(in_a_im) + (DW+1)'(in_b_im);
      prr1_r <= PW'(in_a_re) * PW'(in_b_re);
      pii1_r <= PW'(in_a_im) * PW'(in_b_im);
      pri1_r <= PW'(in_a_re) * PW'(in_b_im);
      pir1_r <= PW'(in_a_im) * PW'(in_b_re);
      sqr1_r <= PW'(in_b_re) * PW'(in_b_re);
      sqi1_r <= PW'(in_b_im) * PW'(in_b_im);
    end
  end

  always_comb begin
    case (op1_r)
      OP_ADD, OP_SUB: begin
        re2_nxt = SW'(sr1_r);
        im2_nxt = SW'(si1_r);
      end
      OP_MUL: begin
        re2_nxt = SW'(prr1_r) - SW'(pii1_r);
        im2_nxt = SW'(pri1_r) + SW'(pir1_r);
      end
      OP_DIV: begin
        re2_nxt = SW'(prr1_r) + SW'(pii1_r);
        im2_nxt = SW'(pir1_r) - SW'(pri1_r);
      end
      default: begin
        re2_nxt = '0;
        im2_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
    if (en2) begin
      op2_r  <= op1_r;
      re2_r  <= re2_nxt;
      im2_r  <= im2_nxt;
      den2_r <= PW'(sqr1_r) + PW'(sqi1_r);
    end
  end

  // Products carry FB fraction bits too many; truncation toward zero is a
  // shift of the magnitude.
  always_comb begin
    mre_nxt = re2_r[SW-1] ? SW'(-re2_r) : SW'(re2_r);
    mim_nxt = im2_r[SW-1] ? SW'(-im2_r) : SW'(im2_r);
    if (op2_r == OP_MUL) begin
      mre_nxt = mre_nxt >> FB;
      mim_nxt = mim_nxt >> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
    if (en3) begin
      div3_r <= (op2_r == OP_DIV);
      dz3_r  <= (op2_r == OP_DIV) && (den2_r == '0);
      nre3_r <= re2_r[SW-1];
      nim3_r <= im2_r[SW-1];
      mre3_r <= mre_nxt;
      mim3_r <= mim_nxt;
      den3_r <= den2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_div    = div3_r;
  assign out_dz     = dz3_r;
  assign out_neg_re = nre3_r;
  assign out_neg_im = nim3_r;
  assign out_mag_re = mre3_r;
  assign out_mag_im = mim3_r;
  assign out_den    = den3_r;

endmodule

/* design/cau_div.sv */
module cau_div import cau_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_div,
  input  logic            in_dz,
  input  logic            in_neg_re,
  input  logic            in_neg_im,
  input  logic [2*DW:0]   in_mag_re,
  input  logic [2*DW:0]   in_mag_im,
  input  logic [2*DW-1:0] in_den,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_dz,
  output logic            out_neg_re,
  output logic            out_neg_im,
  output logic [2*DW:0]   out_mag_re,
  output logic [2*DW:0]   out_mag_im
);

  localparam int PW = 2 * DW;
  localparam int MW = 2 * DW + 1;
  localparam int W  = 3 * DW + FB + 2;
  localparam int NS = DW + 1;
  localparam logic [MW-1:0] CAP = MW'(1) << DW;

  logic          v_r   [0:NS];
  logic          en    [0:NS];
  logic          div_r [0:NS];
  logic          dz_r  [0:NS];
  logic          nre_r [0:NS];
  logic          nim_r [0:NS];
  logic          ore_r [0:NS];
  logic          oim_r [0:NS];
  logic [W-1:0]  rre_r [0:NS];
  logic [W-1:0]  rim_r [0:NS];
  logic [PW-1:0] den_r [0:NS];
  logic [DW:0]   qre_r [0:NS];
  logic [DW:0]   qim_r [0:NS];

  logic [W-1:0] nre_nxt, nim_nxt, dtop_nxt;

  assign en[NS]   = !v_r[NS] || out_ready;
  assign in_ready = en[0];

  // Entry stage: scale the dividend and catch quotients that would not fit
  // in DW+1 bits; those saturate in any case.
  assign nre_nxt  = W'(in_mag_re) << FB;
  assign nim_nxt  = W'(in_mag_im) << FB;
  assign dtop_nxt = W'(in_den) << (DW + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_valid;
    end
    if (en[0]) begin
      div_r[0] <= in_div;
      dz_r[0]  <= in_dz;
      nre_r[0] <= in_neg_re;
      nim_r[0] <= in_neg_im;
      ore_r[0] <= in_div && (nre_nxt >= dtop_nxt);
      oim_r[0] <= in_div && (nim_nxt >= dtop_nxt);
      rre_r[0] <= in_div ? nre_nxt : W'(in_mag_re);
      rim_r[0] <= in_div ? nim_nxt : W'(in_mag_im);
      den_r[0] <= in_den;
      qre_r[0] <= '0;
      qim_r[0] <= '0;
    end
  end

  // One restoring step per stage, quotient bit DW first, bit 0 last.
  for (genvar s = 1; s <= NS; s++) begin : g_step
    localparam int K = DW + 1 - s;
    logic [W-1:0] dsh;
    logic         bre, bim;

    assign en[s-1] = !v_r[s-1] || en[s];
    assign dsh     = W'(den_r[s-1]) << K;
    assign bre     = div_r[s-1] && (rre_r[s-1] >= dsh);
    assign bim     = div_r[s-1] && (rim_r[s-1] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= v_r[s-1];
      end
      if (en[s]) begin
        div_r[s] <= div_r[s-1];
        dz_r[s]  <= dz_r[s-1];
        nre_r[s] <= nre_r[s-1];
        nim_r[s] <= nim_r[s-1];
        ore_r[s] <= ore_r[s-1];
        oim_r[s] <= oim_r[s-1];
        den_r[s] <= den_r[s-1];
        rre_r[s] <= bre ? rre_r[s-1] - dsh : rre_r[s-1];
        rim_r[s] <= bim ? rim_r[s-1] - dsh : rim_r[s-1];
        qre_r[s] <= {qre_r[s-1][DW-1:0], bre};
        qim_r[s] <= {qim_r[s-1][DW-1:0], bim};
      end
    end
  end

  assign out_valid  = v_r[NS];
  assign out_dz     = dz_r[NS];
  assign out_neg_re = nre_r[NS];
  assign out_neg_im = nim_r[NS];
  assign out_mag_re = !div_r[NS] ? rre_r[NS][MW-1:0] :
                      ore_r[NS]  ? CAP : MW'(qre_r[NS]);
  assign out_mag_im = !div_r[NS] ? rim_r[NS][MW-1:0] :
                      oim_r[NS]  ? CAP : MW'(qim_r[NS]);

endmodule

/* design/cau_sat.sv */
module cau_sat import cau_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_dz,
  input  logic          in_neg_re,
  input  logic          in_neg_im,
  input  logic [2*DW:0] in_mag_re,
  input  logic [2*DW:0] in_mag_im,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_re,
  output logic [DW-1:0] out_im,
  output status_t       out_status
);

  localparam int MW = 2 * DW + 1;
  localparam logic [MW-1:0] POS_LIM = (MW'(1) << (DW - 1)) - MW'(1);
  localparam logic [MW-1:0] NEG_LIM = MW'(1) << (DW - 1);

  logic          v_r, en;
  logic [DW-1:0] re_r, im_r, re_nxt, im_nxt;
  status_t       st_r, st_nxt;
  logic          sre, sim;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    sre = in_neg_re ? (in_mag_re > NEG_LIM) : (in_mag_re > POS_LIM);
    sim = in_neg_im ? (in_mag_im > NEG_LIM) : (in_mag_im > POS_LIM);
    if (in_neg_re) begin
      re_nxt = sre ? NEG_LIM[DW-1:0] : DW'(MW'(0) - in_mag_re);
    end else begin
      re_nxt = sre ? POS_LIM[DW-1:0] : in_mag_re[DW-1:0];
    end
    if (in_neg_im) begin
      im_nxt = sim ? NEG_LIM[DW-1:0] : DW'(MW'(0) - in_mag_im);
    end else begin
      im_nxt = sim ? POS_LIM[DW-1:0] : in_mag_im[DW-1:0];
    end
    st_nxt = (sre || sim) ? ST_SAT : ST_OK;
    if (in_dz) begin
      re_nxt = '0;
      im_nxt = '0;
      st_nxt = ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid  = v_r;
  assign out_re     = re_r;
  assign out_im     = im_r;
  assign out_status = st_r;

endmodule

/* design/complex_arith_unit.sv */
// Channel | Direction | Beat contents
// in_     | slave     | tuser[1:0] req_type; tdata a_re, a_im, b_re, b_im (DATA_WIDTH each)
// out_    | master    | tuser[1:0] status; tdata res_re, res_im (DATA_WIDTH each)
//
// One beat is taken every cycle while the output is not stalled; every operation
// passes through the divider, which yields one quotient bit per stage.
// Reset (rst_n, synchronous, active low) empties the pipeline; no other state.
// A stall on out_tready holds only the stages that are full: bubbles close
// up, so the input keeps taking beats until every stage holds one.
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // a_re, a_im, b_re, b_im from bit 0 up, zero padded to whole bytes
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]    in_tdata,
  // req_type
  input  logic [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // res_re, res_im from bit 0 up, zero padded to whole bytes
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]    out_tdata,
  // status
  output logic [1:0]                           out_tuser
);

  localparam int DW     = DATA_WIDTH;
  localparam int OUT_TW = ((2 * DATA_WIDTH + 7) / 8) * 8;

  // Front end to divider.
  logic            f_valid, f_ready, f_div, f_dz, f_nre, f_nim;
  logic [2*DW:0]   f_mre, f_mim;
  logic [2*DW-1:0] f_den;

  // Divider to saturation stage.
  logic            d_valid, d_ready, d_dz, d_nre, d_nim;
  logic [2*DW:0]   d_mre, d_mim;

  logic [DW-1:0]   res_re, res_im;
  status_t         status;

  cau_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (op_t'(in_tuser)),
    .in_a_re    (in_tdata[DW-1:0]),
    .in_a_im    (in_tdata[2*DW-1:DW]),
    .in_b_re    (in_tdata[3*DW-1:2*DW]),
    .in_b_im    (in_tdata[4*DW-1:3*DW]),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_div    (f_div),
    .out_dz     (f_dz),
    .out_neg_re (f_nre),
    .out_neg_im (f_nim),
    .out_mag_re (f_mre),
    .out_mag_im (f_mim),
    .out_den    (f_den)
  );

  cau_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .in_div     (f_div),
    .in_dz      (f_dz),
    .in_neg_re  (f_nre),
    .in_neg_im  (f_nim),
    .in_mag_re  (f_mre),
    .in_mag_im  (f_mim),
    .in_den     (f_den),
    .out_valid  (d_valid),
    .out_ready  (d_ready),
    .out_dz     (d_dz),
    .out_neg_re (d_nre),
    .out_neg_im (d_nim),
    .out_mag_re (d_mre),
    .out_mag_im (d_mim)
  );

  cau_sat #(.DW(DW)) u_sat (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d_valid),
    .in_ready   (d_ready),
    .in_dz      (d_dz),
    .in_neg_re  (d_nre),
    .in_neg_im  (d_nim),
    .in_mag_re  (d_mre),
    .in_mag_im  (d_mim),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_re     (res_re),
    .out_im     (res_im),
    .out_status (status)
  );

  assign out_tdata = OUT_TW'({res_im, res_re});
  assign out_tuser = status;

endmodule
